// File: sv/wbps_pkg.sv
// wbps_pkg: shared constants for the wildcard byte pattern scanner.
// No dependencies; used by wbps_match and wildcard_byte_pattern_scanner.
`default_nettype none

package wbps_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PATTERN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MASK    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LENGTH  = 2'd2;

  // field widths
  localparam int unsigned LEN_W    = 4;
  localparam int unsigned MASK_W   = 8;
  localparam int unsigned OFFSET_W = 32;

  // register reset values
  localparam logic [CFG_DATA_W-1:0] PATTERN_RST = '0;
  localparam logic [MASK_W-1:0]     MASK_RST    = 8'hFF;
  localparam logic [LEN_W-1:0]      LENGTH_RST  = 4'd1;

endpackage

`default_nettype wire

// File: sv/wbps_match.sv
// wbps_match: parallel compare of the byte window against the pattern.
// Depends on wbps_pkg for the length width.
`default_nettype none

module wbps_match #(
  parameter int unsigned MAX_PATTERN_BYTES = 8
) (
  input  wire logic [MAX_PATTERN_BYTES*8-1:0] window_i,   // entry 0 = newest byte
  input  wire logic [MAX_PATTERN_BYTES*8-1:0] pattern_i,
  input  wire logic [MAX_PATTERN_BYTES-1:0]   care_i,
  input  wire logic [wbps_pkg::LEN_W-1:0]     length_i,   // already clamped to 1..MAX
  output logic                                hit_o
);

  logic [7:0] sel;

  // pattern byte i lines up with window entry length-1-i
  always_comb begin
    hit_o = 1'b1;
    sel   = '0;
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
      sel = '0;
      for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
        if (wbps_pkg::LEN_W'(k) ==
            length_i - wbps_pkg::LEN_W'(1) - wbps_pkg::LEN_W'(i)) begin
          sel = window_i[8*k +: 8];
        end
      end
      if ((wbps_pkg::LEN_W'(i) < length_i) && care_i[i] &&
          (sel != pattern_i[8*i +: 8])) begin
        hit_o = 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/wildcard_byte_pattern_scanner.sv
// wildcard_byte_pattern_scanner: top level, config registers, window and result stage.
// Depends on wbps_pkg and wbps_match.
`default_nettype none

// Scans a byte stream, one byte per beat, for the first occurrence of a pattern of up
// to MAX_PATTERN_BYTES bytes with per-byte wildcards (care_mask bit clear). Each region
// ends with the beat carrying region_last; it yields one result beat: found=1 with the
// offset of the match start at the byte completing the first match, or found=0 at the
// last byte when nothing matched. The block takes one byte per cycle unless stalled; a
// byte passes an input register, then the window compare, and its result lands in the
// output register as the byte moves on. Input stalls only while both registers are full
// and out_ready_i is low. The offset counter saturates at 2^OFFSET_BITS-1. The user must
// write configuration via cfg_we_i only while the block is idle; nothing enforces it.
module wildcard_byte_pattern_scanner #(
  parameter int unsigned MAX_PATTERN_BYTES = 8,
  parameter int unsigned OFFSET_BITS       = 32
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // configuration
  input  wire logic                                 cfg_we_i,
  input  wire logic [wbps_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [wbps_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  // byte stream in
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic [7:0]                           data_byte_i,
  input  wire logic                                 region_last_i,
  // results out
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic                                      found_o,
  output logic [wbps_pkg::OFFSET_W-1:0]             match_offset_o
);

  localparam int unsigned WIN_W = MAX_PATTERN_BYTES * 8;

  // config registers
  logic [WIN_W-1:0]                 pat_q;
  logic [MAX_PATTERN_BYTES-1:0]     mask_q;
  logic [wbps_pkg::LEN_W-1:0]       len_q;
  logic [wbps_pkg::LEN_W-1:0]       len_eff;

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // region state
  logic [WIN_W-1:0]       win_q, win_d;
  logic [OFFSET_BITS-1:0] seen_q, seen_d;
  logic [OFFSET_BITS-1:0] diff;
  logic                   reported_q, reported_d;

  // result register
  logic                          out_valid_q;
  logic                          found_q, found_d;
  logic [wbps_pkg::OFFSET_W-1:0] offset_q, offset_d;

  logic adv;
  logic hit;
  logic has_result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q  <= wbps_pkg::PATTERN_RST[WIN_W-1:0];
      mask_q <= wbps_pkg::MASK_RST[MAX_PATTERN_BYTES-1:0];
      len_q  <= wbps_pkg::LENGTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        wbps_pkg::CFG_IDX_PATTERN: pat_q  <= cfg_wdata_i[WIN_W-1:0];
        wbps_pkg::CFG_IDX_MASK:    mask_q <= cfg_wdata_i[MAX_PATTERN_BYTES-1:0];
        wbps_pkg::CFG_IDX_LENGTH:  len_q  <= cfg_wdata_i[wbps_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // length 0 acts as 1, anything above the window acts as the window size
  always_comb begin
    if (len_q == '0) begin
      len_eff = wbps_pkg::LEN_W'(1);
    end else if (len_q > wbps_pkg::LEN_W'(MAX_PATTERN_BYTES)) begin
      len_eff = wbps_pkg::LEN_W'(MAX_PATTERN_BYTES);
    end else begin
      len_eff = len_q;
    end
  end

  // a byte leaves the input register once the result register has room
  assign adv        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= data_byte_i;
      in_last_q <= region_last_i;
    end
  end

  // window with the new byte shifted in at entry 0
  assign win_d  = WIN_W'({win_q, in_byte_q});
  assign seen_d = (seen_q == '1) ? seen_q : seen_q + OFFSET_BITS'(1);
  assign diff   = seen_d - OFFSET_BITS'(len_eff);

  wbps_match #(
    .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
  ) u_match (
    .window_i (win_d),
    .pattern_i(pat_q),
    .care_i   (mask_q),
    .length_i (len_eff),
    .hit_o    (hit)
  );

  always_comb begin
    found_d    = 1'b0;
    offset_d   = '0;
    has_result = 1'b0;
    reported_d = reported_q;
    if (!reported_q) begin
      if ((seen_d >= OFFSET_BITS'(len_eff)) && hit) begin
        found_d    = 1'b1;
        offset_d   = wbps_pkg::OFFSET_W'(diff);
        has_result = 1'b1;
        reported_d = 1'b1;
      end else if (in_last_q) begin
        has_result = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q      <= '0;
      seen_q     <= '0;
      reported_q <= 1'b0;
    end else if (adv) begin
      if (in_last_q) begin
        win_q      <= '0;
        seen_q     <= '0;
        reported_q <= 1'b0;
      end else begin
        win_q      <= win_d;
        seen_q     <= seen_d;
        reported_q <= reported_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && has_result) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && has_result) begin
      found_q  <= found_d;
      offset_q <= offset_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign match_offset_o = offset_q;

`ifndef ASSERT_OFF
  a_notfound_zero_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> match_offset_o == '0)
    else $error("not-found beat with nonzero offset");

  a_match_sets_reported: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && has_result && found_d && !in_last_q |=> reported_q)
    else $error("match reported but flag not set");

  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && !in_last_q |=> (seen_q != '0) && (seen_q >= $past(seen_q)))
    else $error("byte counter went backwards inside a region");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !out_ready_i |-> !in_ready_o)
    else $error("input taken while pipeline is blocked");
`endif

endmodule

`default_nettype wire

// File: verif/tb_wildcard_byte_pattern_scanner.sv
// tb_wildcard_byte_pattern_scanner: self-checking bench for the wildcard byte scanner.
// Needs wbps_pkg and the scanner RTL; stream model, driver and result checker live here.
// Directed and random regions run over several register settings with random stalls.

module tb_wildcard_byte_pattern_scanner;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEN       = 8;
  localparam int WIN_DEPTH     = 8;
  localparam int DRAIN_CYCLES  = 10;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASE_BYTES   = 60;
  localparam int REPORT_LIMIT  = 10;
  localparam logic [wbps_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } scan_beat_t;

  typedef struct packed {
    logic                          found;
    logic [wbps_pkg::OFFSET_W-1:0] offset;
  } scan_report_t;

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            cfg_we_i      = 1'b0;
  logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [wbps_pkg::CFG_DATA_W-1:0] cfg_wdata_i   = '0;
  logic                            in_valid_i    = 1'b0;
  logic                            in_ready_o;
  logic [7:0]                      data_byte_i   = '0;
  logic                            region_last_i = 1'b0;
  logic                            out_valid_o;
  logic                            out_ready_i   = 1'b0;
  logic                            found_o;
  logic [wbps_pkg::OFFSET_W-1:0]   match_offset_o;

  wildcard_byte_pattern_scanner u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .region_last_i (region_last_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .found_o       (found_o),
    .match_offset_o(match_offset_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // scanner model state and its copy of the registers
  logic [63:0]                   pat_reg;
  logic [7:0]                    mask_reg;
  logic [3:0]                    len_reg;
  logic [7:0]                    win [WIN_DEPTH];
  logic [wbps_pkg::OFFSET_W-1:0] seen;
  logic                          reported;

  scan_beat_t   pending_bytes [$];
  scan_report_t expected_reports [$];
  scan_beat_t   next_beat;
  scan_report_t want;

  logic in_taken = 1'b0;
  logic out_fire;
  logic no_idle  = 1'b0;
  logic hold_go  = 1'b0;
  logic hold_done = 1'b0;
  int   hold_cnt = 0;
  int   quiet_cycles = 0;
  int   mismatches = 0;
  int   bytes_scanned = 0;
  int   regions_closed = 0;
  int   hits_reported = 0;
  int   misses_reported = 0;

  function automatic int eff_len(input logic [3:0] l);
    if (l == 4'd0) return 1;
    if (l > MAX_LEN) return MAX_LEN;
    return int'(l);
  endfunction

  task automatic clear_region();
    for (int k = 0; k < WIN_DEPTH; k++) win[k] = 8'h00;
    seen = '0;
    reported = 1'b0;
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic last);
    int           plen;
    logic         hit;
    scan_report_t rep;
    plen = eff_len(len_reg);
    for (int k = WIN_DEPTH - 1; k > 0; k--) win[k] = win[k-1];
    win[0] = b;
    if (seen != '1) seen++;
    bytes_scanned++;
    if (!reported) begin
      hit = (seen >= plen);
      // pattern byte 0 sits oldest in the window
      for (int k = 0; k < plen; k++)
        if (mask_reg[k] && win[plen-1-k] != pat_reg[8*k +: 8]) hit = 1'b0;
      if (hit) begin
        reported = 1'b1;
        rep.found = 1'b1;
        rep.offset = seen - plen;
        expected_reports = {expected_reports, rep};
        hits_reported++;
      end else if (last) begin
        rep.found = 1'b0;
        rep.offset = '0;
        expected_reports = {expected_reports, rep};
        misses_reported++;
      end
    end
    if (last) begin
      clear_region();
      regions_closed++;
    end
  endtask

  task automatic add_beat(input logic [7:0] b, input logic last);
    scan_beat_t bt;
    bt.data = b;
    bt.last = last;
    pending_bytes = {pending_bytes, bt};
  endtask

  // plant may start close to the end, so some planted copies get cut off
  task automatic add_region(input int rlen, input logic plant, input logic close);
    int         plen;
    int         at;
    int         sel;
    logic [7:0] b;
    plen = eff_len(len_reg);
    at = plant ? int'($urandom_range(0, rlen - 1)) : -1;
    for (int k = 0; k < rlen; k++) begin
      if (at >= 0 && k >= at && k < at + plen && mask_reg[k-at]) begin
        b = pat_reg[8*(k-at) +: 8];
      end else if ($urandom_range(0, 4) == 0) begin
        sel = $urandom_range(0, MAX_LEN - 1);
        b = pat_reg[8*sel +: 8];
      end else begin
        b = 8'($urandom);
      end
      add_beat(b, close && (k == rlen - 1));
    end
  endtask

  task automatic write_reg(input logic [wbps_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [wbps_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      wbps_pkg::CFG_IDX_PATTERN: pat_reg = val;
      wbps_pkg::CFG_IDX_MASK:    mask_reg = val[wbps_pkg::MASK_W-1:0];
      wbps_pkg::CFG_IDX_LENGTH:  len_reg = val[wbps_pkg::LEN_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // a byte may still be in flight with no result due, so keep clocking after the queues empty
  task automatic settle();
    while (pending_bytes.size() != 0 || in_valid_i || expected_reports.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // driver: new beat only once the current one is taken
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (pending_bytes.size() != 0 && (no_idle || $urandom_range(0, 99) >= 35)) begin
        next_beat = pending_bytes.pop_front();
        in_valid_i    <= 1'b1;
        data_byte_i   <= next_beat.data;
        region_last_i <= next_beat.last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result side ready, with one long hold-off to back the block up
  always @(negedge clk_i) begin
    if (hold_go && !hold_done) begin
      out_ready_i <= 1'b0;
      hold_cnt++;
      if (hold_cnt >= HOLD_CYCLES) hold_done = 1'b1;
    end else if (no_idle) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= 35);
    end
  end

  // monitor: check results, feed accepted bytes to the model, watch for hangs
  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_fire = out_valid_o && out_ready_i;
      in_taken = in_valid_i && in_ready_o;
      if (out_fire) begin
        if (expected_reports.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("unexpected result beat: found=%0b offset=%0d", found_o, match_offset_o);
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          if (found_o !== want.found || match_offset_o !== want.offset) begin
            if (mismatches < REPORT_LIMIT)
              $display("mismatch: expected found=%0b offset=%0d, got found=%0b offset=%0d",
                       want.found, want.offset, found_o, match_offset_o);
            mismatches++;
          end
        end
      end
      if (in_taken) scan_byte(data_byte_i, region_last_i);
      if (in_taken || out_fire ||
          (pending_bytes.size() == 0 && !in_valid_i && expected_reports.size() == 0)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("watchdog: no beat moved for %0d cycles, %0d results outstanding",
                   quiet_cycles, expected_reports.size());
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  initial begin
    logic [63:0] pat_sel;
    logic [7:0]  mask_sel;
    logic [3:0]  len_sel;
    int          count;
    int          rlen;

    pat_reg  = wbps_pkg::PATTERN_RST;
    mask_reg = wbps_pkg::MASK_RST;
    len_reg  = wbps_pkg::LENGTH_RST;
    clear_region();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: single byte 00, then a region that misses
    @(posedge clk_i);
    add_beat(8'h00, 1'b0);
    add_beat(8'hFF, 1'b0);
    add_beat(8'h00, 1'b1);
    add_beat(8'hFF, 1'b1);
    settle();

    // full eight-byte pattern completing on the region's last byte
    write_reg(wbps_pkg::CFG_IDX_PATTERN, 64'h8877_6655_4433_2211);
    write_reg(wbps_pkg::CFG_IDX_LENGTH, 64'd8);
    @(posedge clk_i);
    for (int k = 0; k < 8; k++) add_beat(8'(8'h11 * (k + 1)), k == 7);
    settle();

    // zero length acts as one; all wildcards hit at once
    write_reg(wbps_pkg::CFG_IDX_LENGTH, 64'd0);
    write_reg(wbps_pkg::CFG_IDX_MASK, 64'h00);
    @(posedge clk_i);
    add_beat(8'hAB, 1'b1);
    settle();

    // oversize length clamps to eight; region too short to hold it
    write_reg(wbps_pkg::CFG_IDX_LENGTH, 64'd15);
    @(posedge clk_i);
    for (int k = 0; k < 5; k++) add_beat(8'($urandom), k == 4);
    settle();

    // spare index is ignored; mask bits past the length don't matter
    write_reg(CFG_IDX_SPARE, '1);
    write_reg(wbps_pkg::CFG_IDX_PATTERN, 64'h5A5A_5A5A_5A5A_FF00);
    write_reg(wbps_pkg::CFG_IDX_MASK, 64'hFF);
    write_reg(wbps_pkg::CFG_IDX_LENGTH, 64'd2);
    @(posedge clk_i);
    add_beat(8'hFF, 1'b0);
    add_beat(8'h00, 1'b0);
    add_beat(8'hFF, 1'b1);

    for (int p = 0; p < 8; p++) begin
      settle();
      no_idle = 1'b0;
      case (p)
        0:       len_sel = 4'd1;
        1:       len_sel = 4'd8;
        2:       len_sel = 4'd0;
        3:       len_sel = 4'd15;
        default: len_sel = 4'($urandom_range(0, 15));
      endcase
      if (p == 1)      mask_sel = 8'hFF;
      else if (p == 5) mask_sel = 8'h00;
      else             mask_sel = $urandom_range(0, 1) ? 8'hFF : 8'($urandom);
      if (p == 2)      pat_sel = '0;
      else if (p == 3) pat_sel = '1;
      else             pat_sel = {$urandom, $urandom};
      write_reg(wbps_pkg::CFG_IDX_PATTERN, pat_sel);
      write_reg(wbps_pkg::CFG_IDX_MASK, 64'(mask_sel));
      write_reg(wbps_pkg::CFG_IDX_LENGTH, 64'(len_sel));
      hold_go = (p == 4);
      no_idle = (p == 6);
      @(posedge clk_i);
      count = 0;
      while (count < PHASE_BYTES) begin
        // hold-off phase uses tiny regions so results pile up
        if (p == 4)                           rlen = $urandom_range(1, 2);
        else if ($urandom_range(0, 7) == 0)   rlen = $urandom_range(21, 70);
        else                                  rlen = $urandom_range(1, 20);
        // phase 2 leaves its last region open across the register change
        add_region(rlen, $urandom_range(0, 9) < 7,
                   !(p == 2 && count + rlen >= PHASE_BYTES));
        count += rlen;
      end
    end
    settle();

    $display("scanned %0d bytes in %0d closed regions over 13 register settings",
             bytes_scanned, regions_closed);
    $display("checked %0d match reports and %0d not-found reports, %0d mismatches",
             hits_reported, misses_reported, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
